// ===== src/cfps_pkg.sv =====
// Shared types and constants for the dual-sum command frame parser.
`default_nettype none

package cfps_pkg;

    // Header bytes
    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'hFF;

    // Frame ids
    localparam logic [7:0] ID_MOVE  = 8'h01;
    localparam logic [7:0] ID_PHOTO = 8'h02;
    localparam logic [7:0] ID_SHOOT = 8'h03;

    // Command kinds on the result channel
    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_PHOTO = 2'd1;
    localparam logic [1:0] KIND_SHOOT = 2'd2;

    // Only frame bytes 4..13 are ever decoded; those are kept as a window.
    localparam int WIN_BASE  = 4;
    localparam int WIN_BYTES = 10;

    typedef logic [WIN_BYTES-1:0][7:0] win_t;

    typedef enum logic [2:0] {
        PH_HEAD1   = 3'd0,
        PH_HEAD2   = 3'd1,
        PH_ID      = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK1  = 3'd5,
        PH_CHECK2  = 3'd6
    } phase_t;

    // Completed frame with good sums and a known id
    typedef struct packed {
        logic       fire;
        logic [1:0] kind;
    } event_t;

endpackage

`default_nettype wire

// ===== src/cfps_parser.sv =====
// Byte-level frame parser: phase FSM, dual running sums and decode window.
`default_nettype none

module cfps_parser #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           hold,
    output cfps_pkg::event_t    evt,
    output cfps_pkg::win_t      win_next
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int OFF_W = $clog2(MAX_PAYLOAD + 2);

    cfps_pkg::phase_t    phase_reg, phase_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          sos_reg, sos_next;
    logic [7:0]          id_reg, id_next;
    logic                sum1_ok_reg, sum1_ok_next;
    cfps_pkg::win_t      win_reg;

    logic                accept;
    logic                wr_en;
    logic [OFF_W-1:0]    wr_off;
    logic [7:0]          add_sum;
    logic [7:0]          add_sos;
    logic                id_known;

    // Only a closing check byte can produce a result, so only it waits.
    assign in_stall = hold && (phase_reg == cfps_pkg::PH_CHECK2);
    assign accept   = in_valid && !in_stall;

    assign add_sum  = sum_reg + rx_byte;
    assign add_sos  = sos_reg + add_sum;
    assign id_known = (id_reg == cfps_pkg::ID_MOVE) || (id_reg == cfps_pkg::ID_PHOTO)
                   || (id_reg == cfps_pkg::ID_SHOOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cfps_pkg::PH_HEAD1;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        sos_next     = sos_reg;
        id_next      = id_reg;
        sum1_ok_next = sum1_ok_reg;
        wr_en        = 1'b0;
        wr_off       = '0;
        evt.fire     = 1'b0;
        evt.kind     = cfps_pkg::KIND_MOVE;

        if (id_reg == cfps_pkg::ID_PHOTO)
        begin
            evt.kind = cfps_pkg::KIND_PHOTO;
        end
        else if (id_reg == cfps_pkg::ID_SHOOT)
        begin
            evt.kind = cfps_pkg::KIND_SHOOT;
        end

        if (accept)
        begin
            case (phase_reg)
                cfps_pkg::PH_HEAD1:
                begin
                    if (rx_byte == cfps_pkg::HEAD_FIRST)
                    begin
                        // sums restart: both hold the first header byte
                        sum_next   = rx_byte;
                        sos_next   = rx_byte;
                        phase_next = cfps_pkg::PH_HEAD2;
                    end
                end
                cfps_pkg::PH_HEAD2:
                begin
                    if (rx_byte == cfps_pkg::HEAD_SECOND)
                    begin
                        sum_next   = add_sum;
                        sos_next   = add_sos;
                        phase_next = cfps_pkg::PH_ID;
                    end
                    else
                    begin
                        phase_next = cfps_pkg::PH_HEAD1;
                    end
                end
                cfps_pkg::PH_ID:
                begin
                    id_next    = rx_byte;
                    sum_next   = add_sum;
                    sos_next   = add_sos;
                    phase_next = cfps_pkg::PH_LEN;
                end
                cfps_pkg::PH_LEN:
                begin
                    if (rx_byte <= 8'(MAX_PAYLOAD))
                    begin
                        len_next   = rx_byte[LEN_W-1:0];
                        idx_next   = '0;
                        sum_next   = add_sum;
                        sos_next   = add_sos;
                        phase_next = cfps_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = cfps_pkg::PH_HEAD1;
                    end
                end
                cfps_pkg::PH_PAYLOAD:
                begin
                    if (len_reg != '0)
                    begin
                        wr_en    = 1'b1;
                        wr_off   = OFF_W'(idx_reg);
                        sum_next = add_sum;
                        sos_next = add_sos;
                        if (({1'b0, idx_reg} + 1'b1) >= {1'b0, len_reg})
                        begin
                            idx_next   = '0;
                            phase_next = cfps_pkg::PH_CHECK1;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // zero-length frame is dropped
                        phase_next = cfps_pkg::PH_HEAD1;
                    end
                end
                cfps_pkg::PH_CHECK1:
                begin
                    wr_en        = 1'b1;
                    wr_off       = OFF_W'(len_reg);
                    sum1_ok_next = (sum_reg == rx_byte);
                    phase_next   = cfps_pkg::PH_CHECK2;
                end
                cfps_pkg::PH_CHECK2:
                begin
                    wr_en      = 1'b1;
                    wr_off     = OFF_W'(len_reg) + 1'b1;
                    evt.fire   = sum1_ok_reg && (sos_reg == rx_byte) && id_known;
                    phase_next = cfps_pkg::PH_HEAD1;
                end
                default:
                begin
                    phase_next = cfps_pkg::PH_HEAD1;
                end
            endcase
        end
    end

    // Window after this beat's write; check bytes of a short frame land here too.
    always_comb
    begin
        for (int k = 0; k < cfps_pkg::WIN_BYTES; k++)
        begin
            win_next[k] = (wr_en && (wr_off == OFF_W'(k))) ? rx_byte : win_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            sos_reg     <= '0;
            id_reg      <= '0;
            sum1_ok_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            sos_reg     <= sos_next;
            id_reg      <= id_next;
            sum1_ok_reg <= sum1_ok_next;
            win_reg     <= win_next;
        end
    end

    // A zero-length frame sits in the payload phase with index and length both zero.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == cfps_pkg::PH_PAYLOAD) && (len_reg != '0)) |-> (idx_reg < len_reg))
        else $error("payload index past length");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LEN_W'(MAX_PAYLOAD)))
        else $error("stored length above limit");

    a_sum_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == cfps_pkg::PH_HEAD1) && (rx_byte == cfps_pkg::HEAD_FIRST))
        |=> ((sum_reg == cfps_pkg::HEAD_FIRST) && (sos_reg == cfps_pkg::HEAD_FIRST)))
        else $error("sums not restarted on header");

endmodule

`default_nettype wire

// ===== src/cfps_result.sv =====
// Result register: formats the decoded command and holds it for the output beat.
`default_nettype none

module cfps_result (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfps_pkg::event_t  evt,
    input  wire cfps_pkg::win_t    win_next,
    output logic                   hold,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             command_kind,
    output logic signed [15:0]     move_x,
    output logic signed [15:0]     move_y,
    output logic signed [15:0]     rotate_speed,
    output logic signed [15:0]     yaw_angle,
    output logic signed [15:0]     pitch_angle,
    output logic [7:0]             photo_count,
    output logic [7:0]             shoot_count,
    output logic [15:0]            shoot_speed
);

    logic        valid_reg, valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] mx_reg, my_reg, rot_reg, yaw_reg, pit_reg, spd_reg;
    logic [7:0]  pcnt_reg, scnt_reg;
    logic        is_move, is_photo, is_shoot;

    assign is_move  = (evt.kind == cfps_pkg::KIND_MOVE);
    assign is_photo = (evt.kind == cfps_pkg::KIND_PHOTO);
    assign is_shoot = (evt.kind == cfps_pkg::KIND_SHOOT);

    assign hold       = valid_reg && out_stall;
    assign valid_next = evt.fire || hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Little-endian words; fields of other kinds read as zero.
    always_ff @(posedge clk)
    begin
        if (evt.fire)
        begin
            kind_reg <= evt.kind;
            mx_reg   <= is_move  ? {win_next[1], win_next[0]} : 16'h0000;
            my_reg   <= is_move  ? {win_next[3], win_next[2]} : 16'h0000;
            rot_reg  <= is_move  ? {win_next[5], win_next[4]} : 16'h0000;
            yaw_reg  <= is_move  ? {win_next[7], win_next[6]} : 16'h0000;
            pit_reg  <= is_move  ? {win_next[9], win_next[8]} : 16'h0000;
            pcnt_reg <= is_photo ? win_next[0] : 8'h00;
            scnt_reg <= is_shoot ? win_next[0] : 8'h00;
            spd_reg  <= is_shoot ? {win_next[3], win_next[2]} : 16'h0000;
        end
    end

    assign out_valid    = valid_reg;
    assign command_kind = kind_reg;
    assign move_x       = signed'(mx_reg);
    assign move_y       = signed'(my_reg);
    assign rotate_speed = signed'(rot_reg);
    assign yaw_angle    = signed'(yaw_reg);
    assign pitch_angle  = signed'(pit_reg);
    assign photo_count  = pcnt_reg;
    assign shoot_count  = scnt_reg;
    assign shoot_speed  = spd_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !evt.fire)
        else $error("new result while previous one is stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((command_kind == cfps_pkg::KIND_MOVE)
                    || (command_kind == cfps_pkg::KIND_PHOTO)
                    || (command_kind == cfps_pkg::KIND_SHOOT)))
        else $error("undefined command kind");

    a_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (command_kind != cfps_pkg::KIND_MOVE))
        |-> ((move_x == 16'sd0) && (pitch_angle == 16'sd0)))
        else $error("move fields set on non-move command");

endmodule

`default_nettype wire

// ===== src/command_frame_parser_dual_sum_top.sv =====
// Top level of the dual-sum checked serial frame parser.
//
//  channel | signals                        | beat
//  --------+--------------------------------+------------------------------------------
//  in      | in_valid, in_stall, rx_byte    | one received serial byte
//  out     | out_valid, out_stall, command_kind, move_x, move_y, rotate_speed,
//          | yaw_angle, pitch_angle, photo_count, shoot_count, shoot_speed
//          |                                | one decoded command (zero or one per in beat)
//
// Cycles: one input beat per clock unless stalled; the parser state updates at the accepting
//   edge and the decoded command appears in the result register on the following cycle.
// Reset: async, active low; parser returns to header hunt, sums, length, index, id and
//   the decode window (frame bytes 4..13) clear to zero at once.
// Stalls: out_stall holds the result register; only the closing check byte of a frame
//   is stalled then (in_stall), all other bytes keep flowing.
`default_nettype none

module command_frame_parser_dual_sum_top #(
    parameter int MAX_PAYLOAD = 14
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         command_kind,
    output logic signed [15:0] move_x,
    output logic signed [15:0] move_y,
    output logic signed [15:0] rotate_speed,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] pitch_angle,
    output logic [7:0]         photo_count,
    output logic [7:0]         shoot_count,
    output logic [15:0]        shoot_speed
);

    cfps_pkg::event_t evt;
    cfps_pkg::win_t   win_next;
    logic             hold;

    // Phase FSM, dual sums and the decode window
    cfps_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .hold     (hold),
        .evt      (evt),
        .win_next (win_next)
    );

    // Field formatting and output register
    cfps_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .win_next     (win_next),
        .hold         (hold),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_kind (command_kind),
        .move_x       (move_x),
        .move_y       (move_y),
        .rotate_speed (rotate_speed),
        .yaw_angle    (yaw_angle),
        .pitch_angle  (pitch_angle),
        .photo_count  (photo_count),
        .shoot_count  (shoot_count),
        .shoot_speed  (shoot_speed)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for the dual-sum frame parser: table-driven frames, then random traffic.
module tb_top;
    import cfps_pkg::*;

    // Must match the parameter of the block under test.
    localparam int MAX_PAYLOAD = 14;
    localparam int STORE_BYTES = MAX_PAYLOAD + 6;

    // One decoded command, laid out like the result ports.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] rot;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic [7:0]         photos;
        logic [7:0]         shots;
        logic [15:0]        shot_speed;
    } cmd_t;

    // A table row is either a complete frame (check bytes worked out here, optionally spoiled)
    // or a run of raw bytes. Rows with a typed expectation bypass the predictor.
    typedef enum logic {ROW_FRAME, ROW_RAW} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [7:0]       id;
        logic [3:0]       len;       // payload length, or raw byte count
        logic [13:0][7:0] body;      // byte 0 in the low bits
        logic [1:0]       spoil;     // bit 0 flips the first check byte, bit 1 the second
        logic             has_exp;
        logic             exp_fire;
        cmd_t             exp;
    } row_t;

    localparam cmd_t NO_CMD = '0;

    localparam row_t DIRECTED [12] = '{
        // first frame out of reset: one-byte photo
        '{ROW_FRAME, ID_PHOTO, 4'd1, 112'h05, 2'b00, 1'b1, 1'b1,
          '{KIND_PHOTO, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'h05, 8'h00, 16'h0}},
        // move with word extremes: x min, y max, rot -1, yaw 1, pitch 0
        '{ROW_FRAME, ID_MOVE, 4'd10, 112'h0000_0001_FFFF_7FFF_8000, 2'b00, 1'b1, 1'b1,
          '{KIND_MOVE, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0001, 16'sh0000,
            8'h00, 8'h00, 16'h0}},
        // shoot with all-ones count and speed
        '{ROW_FRAME, ID_SHOOT, 4'd4, 112'hFFFF_00FF, 2'b00, 1'b1, 1'b1,
          '{KIND_SHOOT, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'h00, 8'hFF, 16'hFFFF}},
        // short shoot: speed comes from its own check byte and a stale byte
        '{ROW_FRAME, ID_SHOOT, 4'd1, 112'h00, 2'b00, 1'b0, 1'b0, NO_CMD},
        // longest payload
        '{ROW_FRAME, ID_MOVE, 4'd14, 112'h3C5A_9600_E7E7_1234_0FF0_8001_7FFE, 2'b00,
          1'b0, 1'b0, NO_CMD},
        // bad first check byte
        '{ROW_FRAME, ID_PHOTO, 4'd1, 112'h11, 2'b01, 1'b1, 1'b0, NO_CMD},
        // bad second check byte
        '{ROW_FRAME, ID_SHOOT, 4'd2, 112'hABCD, 2'b10, 1'b1, 1'b0, NO_CMD},
        // good sums, unknown id
        '{ROW_FRAME, 8'h00, 4'd2, 112'h0102, 2'b00, 1'b1, 1'b0, NO_CMD},
        // zero length: the byte after it kills the frame, even a header byte
        '{ROW_RAW, 8'h00, 4'd5, 112'hAA_00_02_FF_AA, 2'b00, 1'b1, 1'b0, NO_CMD},
        // second 0xAA while waiting for 0xFF does not restart the header
        '{ROW_RAW, 8'h00, 4'd4, 112'h01_FF_AA_AA, 2'b00, 1'b1, 1'b0, NO_CMD},
        // length one past the maximum
        '{ROW_RAW, 8'h00, 4'd4, 112'h0F_01_FF_AA, 2'b00, 1'b1, 1'b0, NO_CMD},
        // recovery after the junk above
        '{ROW_FRAME, ID_PHOTO, 4'd1, 112'h80, 2'b00, 1'b1, 1'b1,
          '{KIND_PHOTO, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 8'h80, 8'h00, 16'h0}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         command_kind;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [15:0] rotate_speed;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic [7:0]         photo_count;
    logic [7:0]         shoot_count;
    logic [15:0]        shoot_speed;

    // Percent of cycles in which the sender holds off / the receiver stalls.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int beats_sent = 0;
    int mismatch_count = 0;

    // Commands the parser owes us, oldest first.
    cmd_t pending_cmds[$];

    // Predictor copy of the parser state.
    phase_t     ph;
    logic [3:0] plen;
    logic [3:0] pidx;
    logic [7:0] store [STORE_BYTES];
    logic [7:0] sum1;
    logic [7:0] sum2;

    command_frame_parser_dual_sum_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .command_kind(command_kind),
        .move_x(move_x),
        .move_y(move_y),
        .rotate_speed(rotate_speed),
        .yaw_angle(yaw_angle),
        .pitch_angle(pitch_angle),
        .photo_count(photo_count),
        .shoot_count(shoot_count),
        .shoot_speed(shoot_speed)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure, independent of anything the block does.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    task automatic fold_sum(input logic [7:0] b);
        sum1 = sum1 + b;
        sum2 = sum2 + sum1;
    endtask

    // Advance the predicted parser by one accepted byte; fire is set when a command is due.
    task automatic parse_byte(input logic [7:0] b, output bit fire, output cmd_t c);
        bit done;
        done = 1'b0;
        fire = 1'b0;
        c = '0;
        if (ph == PH_HEAD1 && b == HEAD_FIRST)
        begin
            sum1 = '0;
            sum2 = '0;
            store[0] = b;
            fold_sum(b);
            ph = PH_HEAD2;
        end
        else if (ph == PH_HEAD2 && b == HEAD_SECOND)
        begin
            store[1] = b;
            fold_sum(b);
            ph = PH_ID;
        end
        else if (ph == PH_ID)
        begin
            store[2] = b;
            fold_sum(b);
            ph = PH_LEN;
        end
        else if (ph == PH_LEN && b <= MAX_PAYLOAD)
        begin
            store[3] = b;
            fold_sum(b);
            plen = b[3:0];
            pidx = '0;
            ph = PH_PAYLOAD;
        end
        else if (ph == PH_PAYLOAD && plen > 0 && plen <= MAX_PAYLOAD)
        begin
            if (pidx < plen)
                store[4 + pidx] = b;
            fold_sum(b);
            pidx = pidx + 1'b1;
            if (pidx >= plen)
            begin
                pidx = '0;
                ph = PH_CHECK1;
            end
        end
        else if (ph == PH_CHECK1 && plen <= MAX_PAYLOAD)
        begin
            store[4 + plen] = b;
            ph = PH_CHECK2;
        end
        else if (ph == PH_CHECK2 && plen <= MAX_PAYLOAD)
        begin
            store[5 + plen] = b;
            ph = PH_HEAD1;
            done = 1'b1;
        end
        else
            ph = PH_HEAD1;

        if (done && sum1 == store[4 + plen] && sum2 == store[5 + plen])
        begin
            // words are little-endian at fixed store offsets, whatever the length was
            if (store[2] == ID_MOVE)
            begin
                fire = 1'b1;
                c.kind = KIND_MOVE;
                c.mx = {store[5], store[4]};
                c.my = {store[7], store[6]};
                c.rot = {store[9], store[8]};
                c.yaw = {store[11], store[10]};
                c.pitch = {store[13], store[12]};
            end
            else if (store[2] == ID_PHOTO)
            begin
                fire = 1'b1;
                c.kind = KIND_PHOTO;
                c.photos = store[4];
            end
            else if (store[2] == ID_SHOOT)
            begin
                fire = 1'b1;
                c.kind = KIND_SHOOT;
                c.shots = store[4];
                c.shot_speed = {store[7], store[6]};
            end
        end
    endtask

    // Present one beat, wait for it to be taken, then let the predictor see it.
    // With use_model clear the caller supplies the expectation itself.
    task automatic send_beat(input logic [7:0] b, input bit use_model);
        bit   fire;
        cmd_t c;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'($urandom);     // junk on an idle bus must be ignored
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        parse_byte(b, fire, c);
        if (fire && use_model)
            pending_cmds.push_back(c);
    endtask

    // Whole frame with its two check bytes; spoil flips the low bit of either one.
    task automatic send_frame(input logic [7:0] id, input logic [3:0] len,
                              input logic [13:0][7:0] body, input logic [1:0] spoil,
                              input bit use_model);
        logic [7:0] a;
        logic [7:0] s;
        a = HEAD_FIRST;
        s = a;
        a = a + HEAD_SECOND;
        s = s + a;
        a = a + id;
        s = s + a;
        a = a + len;
        s = s + a;
        for (int i = 0; i < len; i++)
        begin
            a = a + body[i];
            s = s + a;
        end
        send_beat(HEAD_FIRST, use_model);
        send_beat(HEAD_SECOND, use_model);
        send_beat(id, use_model);
        send_beat({4'h0, len}, use_model);
        for (int i = 0; i < len; i++)
            send_beat(body[i], use_model);
        send_beat(a ^ {7'd0, spoil[0]}, use_model);
        send_beat(s ^ {7'd0, spoil[1]}, use_model);
    endtask

    // One random chunk of traffic: mostly well-formed frames, some junk and broken frames.
    task automatic send_random_chunk();
        int               pick;
        logic [7:0]       id;
        logic [3:0]       len;
        logic [13:0][7:0] body;
        logic [1:0]       spoil;
        int               cut;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 14; i++)
            body[i] = 8'($urandom);
        if ($urandom_range(0, 99) < 85)
            id = 8'($urandom_range(1, 3));
        else
            id = 8'($urandom);
        if (pick < 75)
        begin
            len = ($urandom_range(0, 99) < 6) ? 4'd0 : 4'($urandom_range(1, MAX_PAYLOAD));
            spoil = 2'b00;
            if ($urandom_range(0, 99) < 8)
                spoil = 2'($urandom_range(1, 3));
            send_frame(id, len, body, spoil, 1'b1);
        end
        else if (pick < 85)
        begin
            // line noise, heavy on header bytes
            repeat ($urandom_range(1, 8))
            begin
                case ($urandom_range(0, 3))
                    0: send_beat(HEAD_FIRST, 1'b1);
                    1: send_beat(HEAD_SECOND, 1'b1);
                    default: send_beat(8'($urandom), 1'b1);
                endcase
            end
        end
        else if (pick < 93)
        begin
            // frame cut short; whatever follows lands inside it
            len = 4'($urandom_range(1, MAX_PAYLOAD));
            cut = $urandom_range(0, len - 1);
            send_beat(HEAD_FIRST, 1'b1);
            send_beat(HEAD_SECOND, 1'b1);
            send_beat(id, 1'b1);
            send_beat({4'h0, len}, 1'b1);
            for (int i = 0; i < cut; i++)
                send_beat(body[i], 1'b1);
        end
        else
        begin
            // oversize length byte
            send_beat(HEAD_FIRST, 1'b1);
            send_beat(HEAD_SECOND, 1'b1);
            send_beat(id, 1'b1);
            send_beat(8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b1);
        end
    endtask

    // Sender holds off until every owed command has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: every taken beat must match the oldest owed command.
    always @(posedge clk)
    begin
        cmd_t c;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: command beat with none owed, kind %0d", $time, command_kind);
                mismatch_count++;
            end
            else
            begin
                c = pending_cmds.pop_front();
                check_field("command_kind", c.kind, command_kind);
                check_field("move_x", c.mx, move_x);
                check_field("move_y", c.my, move_y);
                check_field("rotate_speed", c.rot, rotate_speed);
                check_field("yaw_angle", c.yaw, yaw_angle);
                check_field("pitch_angle", c.pitch, pitch_angle);
                check_field("photo_count", c.photos, photo_count);
                check_field("shoot_count", c.shots, shoot_count);
                check_field("shoot_speed", c.shot_speed, shoot_speed);
            end
        end
    end

    // Main sequence.
    initial
    begin
        row_t row;

        // predictor starts from the reset state, store cleared
        ph = PH_HEAD1;
        plen = '0;
        pidx = '0;
        sum1 = '0;
        sum2 = '0;
        foreach (store[i])
            store[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first setting: sender idles a little, receiver a lot
        send_idle_pct = 27;
        recv_idle_pct = 82;

        foreach (DIRECTED[r])
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_FRAME)
                send_frame(row.id, row.len, row.body, row.spoil, !row.has_exp);
            else
                for (int i = 0; i < row.len; i++)
                    send_beat(row.body[i], !row.has_exp);
            if (row.has_exp && row.exp_fire)
                pending_cmds.push_back(row.exp);
        end

        while (beats_sent < 650)
            send_random_chunk();
        drain();

        // flip it: slow sender, mostly ready receiver
        send_idle_pct = 82;
        recv_idle_pct = 27;
        while (beats_sent < 1200)
            send_random_chunk();
        drain();

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (beats_sent < 1800)
            send_random_chunk();
        drain();

        // room for any stray late command to show up
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("command_frame_parser_dual_sum_top verification clean");
        else
            $display("command_frame_parser_dual_sum_top verification failed");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("%0t: timeout, %0d commands still owed", $time, pending_cmds.size());
        $display("command_frame_parser_dual_sum_top verification failed");
        $finish;
    end

endmodule
